// File: sv/deqs_pkg.sv
// Shared types and constants for the double-ended queue with search.
// Holds the command and result transfer structs, op and status codes.
// No dependencies.
package deqs_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned OpW      = 3;
  localparam int unsigned ValW     = 32;
  localparam int unsigned StatW    = 2;
  localparam int unsigned OccW     = 5;

  localparam logic [OpW-1:0] OpPushFront = 3'd0;
  localparam logic [OpW-1:0] OpPushBack  = 3'd1;
  localparam logic [OpW-1:0] OpPopFront  = 3'd2;
  localparam logic [OpW-1:0] OpPopBack   = 3'd3;
  localparam logic [OpW-1:0] OpSearch    = 3'd4;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StEmpty = 2'd1;
  localparam logic [StatW-1:0] StFull  = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic signed [ValW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             found;
    logic [OccW-1:0]  occupancy;
  } result_t;

  function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] base,
                                               input logic [IdxW-1:0] offset);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IdxW + 1)'(Capacity)) begin
      sum = sum - (IdxW + 1)'(Capacity);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

// File: sv/double_ended_queue_with_search_unit.sv
// Push and pop results strobe the cycle after the transfer,
// and busy stays low for them, so one command is taken every cycle while no search runs.
// A search reads one entry per cycle from the entry memory port, from the head on,
// until it finds a match or has read every occupied entry.
// Reset empties the queue (head and count to zero); entry contents stay undefined.
// The receiver cannot stall: each result is valid for exactly one cycle.
module double_ended_queue_with_search_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  deqs_pkg::cmd_t    cmd_i,
  output logic              done_o,
  output deqs_pkg::result_t result_o
);

  localparam logic StIdle   = 1'b0;
  localparam logic StSearch = 1'b1;

  logic                            state_q, state_d;
  logic [deqs_pkg::IdxW-1:0]       head_q, head_d;
  logic [deqs_pkg::CntW-1:0]       count_q, count_d;
  logic [deqs_pkg::IdxW-1:0]       pos_q, pos_d;
  logic signed [deqs_pkg::ValW-1:0] key_q, key_d;
  logic                            done_q, done_d;
  deqs_pkg::result_t               res_q, res_d;

  logic                            we;
  logic [deqs_pkg::IdxW-1:0]       waddr;
  logic [deqs_pkg::IdxW-1:0]       raddr;
  logic signed [deqs_pkg::ValW-1:0] rdata;
  logic                            accept;
  logic                            full;
  logic                            empty;
  logic                            last;

  deqs_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy   = (state_q == StSearch);
  assign accept = start && !busy;
  assign full   = (count_q >= deqs_pkg::CntW'(deqs_pkg::Capacity));
  assign empty  = (count_q == '0);
  assign last   = ((deqs_pkg::CntW'(pos_q) + deqs_pkg::CntW'(1)) == count_q);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    key_d   = key_q;
    done_d  = 1'b0;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = deqs_pkg::ring_add(head_q, count_q[deqs_pkg::IdxW-1:0]);
    raddr   = head_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_d.status = deqs_pkg::StOk;
          res_d.found  = 1'b0;
          done_d       = 1'b1;
          unique case (cmd_i.op)
            deqs_pkg::OpPushFront: begin
              if (full) begin
                res_d.status = deqs_pkg::StFull;
              end else begin
                head_d  = deqs_pkg::ring_add(head_q,
                                             deqs_pkg::IdxW'(deqs_pkg::Capacity - 1));
                waddr   = head_d;
                we      = 1'b1;
                count_d = count_q + deqs_pkg::CntW'(1);
              end
            end
            deqs_pkg::OpPushBack: begin
              if (full) begin
                res_d.status = deqs_pkg::StFull;
              end else begin
                we      = 1'b1;
                count_d = count_q + deqs_pkg::CntW'(1);
              end
            end
            deqs_pkg::OpPopFront: begin
              if (empty) begin
                res_d.status = deqs_pkg::StEmpty;
              end else begin
                head_d  = deqs_pkg::ring_add(head_q, deqs_pkg::IdxW'(1));
                count_d = count_q - deqs_pkg::CntW'(1);
              end
            end
            deqs_pkg::OpPopBack: begin
              if (empty) begin
                res_d.status = deqs_pkg::StEmpty;
              end else begin
                count_d = count_q - deqs_pkg::CntW'(1);
              end
            end
            deqs_pkg::OpSearch: begin
              if (!empty) begin
                done_d  = 1'b0;
                key_d   = cmd_i.value;
                pos_d   = '0;
                state_d = StSearch;
              end
            end
            default: begin
            end
          endcase
          res_d.occupancy = deqs_pkg::OccW'(count_d);
        end
      end
      StSearch: begin
        raddr = deqs_pkg::ring_add(head_q, pos_q + deqs_pkg::IdxW'(1));
        if ((rdata == key_q) || last) begin
          res_d.status    = deqs_pkg::StOk;
          res_d.found     = (rdata == key_q);
          res_d.occupancy = deqs_pkg::OccW'(count_q);
          done_d          = 1'b1;
          state_d         = StIdle;
        end else begin
          pos_d = pos_q + deqs_pkg::IdxW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: sv/deqs_store.sv
// Entry storage of the queue: one write port, one read port.
// Read data is registered. Uses deqs_pkg.
module deqs_store (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [deqs_pkg::IdxW-1:0]       waddr_i,
  input  logic signed [deqs_pkg::ValW-1:0] wdata_i,
  input  logic [deqs_pkg::IdxW-1:0]       raddr_i,
  output logic signed [deqs_pkg::ValW-1:0] rdata_o
);

  logic signed [deqs_pkg::ValW-1:0] mem [deqs_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
